/* hw/rtl/d2r_pkg.sv */
// d2r_pkg: shared types, constants and helpers for the depth to rgb encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package d2r_pkg;

  // field widths
  localparam int DEPTH_W  = 13;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 2 * DEPTH_W;          // 13x13 product
  localparam int QUO_W    = 9;                    // quotient stays below 383
  localparam int NUM_W    = PROD_W + BYTE_W;      // 255 * product
  localparam int DEN_SH_W = PROD_W + QUO_W - 1;   // divisor aligned to top quotient bit
  localparam int DIV_STEPS = QUO_W;
  localparam int SCALE_W  = DEPTH_W + 1;          // 2d+1 and 2*far
  localparam int ADAPT_W  = SCALE_W + BYTE_W;     // 255 * (2d+1)

  // register reset values
  localparam logic [DEPTH_W-1:0] NEAR_RESET = 13'd400;
  localparam logic [DEPTH_W-1:0] FAR_RESET  = 13'd3000;

  // encoding modes (code 3 is unused and skips every pixel)
  typedef enum logic [1:0] {
    MODE_GRAY  = 2'd0,
    MODE_RAW   = 2'd1,
    MODE_ADAPT = 2'd2
  } mode_t;

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_NEAR = 2'd1,
    REG_FAR  = 2'd2
  } reg_idx_t;

  // how the output bytes are picked at the end of the pipe
  typedef enum logic [1:0] {
    SEL_GRAY  = 2'd0,
    SEL_RAW   = 2'd1,
    SEL_ADAPT = 2'd2
  } sel_t;

  // data that rides beside the divider
  typedef struct packed {
    logic              ok;
    logic              last;
    sel_t              sel;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } side_t;

  // one beat moving through the divider cells
  typedef struct packed {
    logic                valid;
    logic [NUM_W-1:0]    rem;
    logic [DEN_SH_W-1:0] den;
    logic [QUO_W-1:0]    quo;
    side_t               side;
  } div_beat_t;

  // finished pixel
  typedef struct packed {
    logic              last;
    logic              in_range;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_t;

  // triangle wave of period 1024 scaled to a byte: floor(255*u/512)
  function automatic logic [BYTE_W-1:0] tri_byte(input logic [9:0] t);
    logic [10:0] u;
    logic [18:0] m;
    u = (t > 10'd512) ? (11'd1024 - {1'b0, t}) : {1'b0, t};
    m = {u, 8'b0} - {8'b0, u};
    return m[16:9];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/d2r_front.sv */
// d2r_front: depth decode, range checks, side bytes and the two products
// depends on d2r_pkg; feeds the first divider cell
`timescale 1ns / 1ps
`default_nettype none

module d2r_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [d2r_pkg::WORD_W-1:0]        in_word,
  input  logic                              in_last,
  input  logic [1:0]                        mode,
  input  logic [d2r_pkg::DEPTH_W-1:0]       near_limit,
  input  logic [d2r_pkg::DEPTH_W-1:0]       far_limit,
  output d2r_pkg::div_beat_t                out_beat
);
  import d2r_pkg::*;

  logic [DEPTH_W-1:0] d;
  logic [SCALE_W-1:0] s;
  logic               gray_ok;
  logic               adapt_ok;
  side_t              side_next;

  logic               s1_valid;
  side_t              s1_side;
  logic [DEPTH_W-1:0] s1_d;
  logic [DEPTH_W-1:0] s1_near;
  logic [DEPTH_W-1:0] s1_far;
  logic [DEPTH_W-1:0] s1_far_m_d;
  logic [DEPTH_W-1:0] s1_far_m_near;

  logic               s2_valid;
  side_t              s2_side;
  logic [PROD_W-1:0]  s2_p;
  logic [PROD_W-1:0]  s2_q;
  logic [SCALE_W-1:0] s2_s;
  logic [DEPTH_W-1:0] s2_far;

  logic [ADAPT_W-1:0] adapt_num;
  div_beat_t          beat_next;

  // decode and classify the pixel
  always_comb begin
    d        = in_word[WORD_W-1:WORD_W-DEPTH_W];
    s        = {d, 1'b1};
    gray_ok  = (near_limit < far_limit) && (d != '0) &&
               (d >= near_limit) && (d <= far_limit);
    adapt_ok = (far_limit != '0) && (d <= far_limit);
    side_next       = '0;
    side_next.last  = in_last;
    case (mode)
      MODE_GRAY: begin
        side_next.sel = SEL_GRAY;
        side_next.ok  = gray_ok;
      end
      MODE_RAW: begin
        side_next.sel   = SEL_RAW;
        side_next.ok    = 1'b1;
        side_next.blue  = {3'b0, d[12:10], 2'b0};
        side_next.green = {d[9:5], 3'b0};
        side_next.red   = {d[4:0], 3'b0};
      end
      MODE_ADAPT: begin
        side_next.sel   = SEL_ADAPT;
        side_next.ok    = adapt_ok;
        side_next.green = tri_byte(s[9:0]);
        side_next.red   = tri_byte(s[9:0] + 10'd768);
      end
      default: begin
        side_next.sel = SEL_RAW;
        side_next.ok  = 1'b0;
      end
    endcase
  end

  // stage 1 and 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // stage 1 payload: differences
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side       <= side_next;
      s1_d          <= d;
      s1_near       <= near_limit;
      s1_far        <= far_limit;
      s1_far_m_d    <= far_limit - d;
      s1_far_m_near <= far_limit - near_limit;
    end
  end

  // stage 2 payload: numerator and denominator products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_p    <= PROD_W'(s1_near) * PROD_W'(s1_far_m_d);
      s2_q    <= PROD_W'(s1_d) * PROD_W'(s1_far_m_near);
      s2_s    <= {s1_d, 1'b1};
      s2_far  <= s1_far;
    end
  end

  // stage 3: scale by 255 and align the divisor
  always_comb begin
    adapt_num = {s2_s, 8'b0} - {8'b0, s2_s};
    beat_next       = '0;
    beat_next.side  = s2_side;
    case (s2_side.sel)
      SEL_GRAY: begin
        beat_next.rem = {s2_p, 8'b0} - {8'b0, s2_p};
        beat_next.den = {s2_q, 8'b0};
      end
      SEL_ADAPT: begin
        beat_next.rem = NUM_W'(adapt_num);
        beat_next.den = DEN_SH_W'({s2_far, 1'b0, 8'b0});
      end
      default: begin
        beat_next.rem = '0;
        beat_next.den = '0;
      end
    endcase
  end

  // stage 3 register, valid cleared by reset
  always_ff @(posedge clk) begin
    if (en) begin
      out_beat.rem  <= beat_next.rem;
      out_beat.den  <= beat_next.den;
      out_beat.quo  <= beat_next.quo;
      out_beat.side <= beat_next.side;
    end
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else if (en) begin
      out_beat.valid <= s2_valid;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/d2r_div_cell.sv */
// d2r_div_cell: one restoring division step, one quotient bit per cell
// depends on d2r_pkg; cells are chained, each halving the aligned divisor
`timescale 1ns / 1ps
`default_nettype none

module d2r_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  d2r_pkg::div_beat_t in_beat,
  output d2r_pkg::div_beat_t out_beat
);
  import d2r_pkg::*;

  logic ge;

  // trial subtract
  assign ge = (in_beat.rem >= NUM_W'(in_beat.den));

  // shift quotient, pass divisor down one bit; valid cleared by reset
  always_ff @(posedge clk) begin
    if (en) begin
      out_beat.rem  <= ge ? (in_beat.rem - NUM_W'(in_beat.den)) : in_beat.rem;
      out_beat.den  <= in_beat.den >> 1;
      out_beat.quo  <= {in_beat.quo[QUO_W-2:0], ge};
      out_beat.side <= in_beat.side;
    end
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else if (en) begin
      out_beat.valid <= in_beat.valid;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/d2r_skid.sv */
// d2r_skid: output register with one spare slot so tready is registered
// depends on d2r_pkg for the pixel type
`timescale 1ns / 1ps
`default_nettype none

module d2r_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  d2r_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output d2r_pkg::pixel_t out_data
);
  import d2r_pkg::*;

  logic   spare_valid;
  pixel_t spare_data;

  assign in_ready = !spare_valid;

  // control: output slot and spare slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !spare_valid) begin
      spare_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= spare_valid ? spare_data : in_data;
    end else if (in_valid && !spare_valid) begin
      spare_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/depth_to_rgb_encoder.sv */
// depth_to_rgb_encoder: top level, config registers, divider chain, output select
// depends on d2r_pkg, d2r_front, d2r_div_cell and d2r_skid
//
//   channel   dir  signals                   beat contents
//   s_*       in   tvalid tready tdata tlast  tdata: depth_word; tlast: frame_end
//   m_*       out  tvalid tready tdata tuser  tdata: blue green red; tuser: in_range;
//                  tlast                      tlast: frame_last
//   apb       in   psel penable pwrite paddr  0x0 encoding_mode, 0x4 near_limit,
//                  pwdata prdata pready       0x8 far_limit
//
// one pixel per clock unless m_tready stalls; the pipe holds 3 front stages
// (decode, 13x13 products, scaling), 9 divider cells, 1 output register.
// reset is synchronous; it empties the pipe and loads the register defaults.
// a stall on m_tready fills the spare output slot, which freezes the whole
// pipe and drops s_tready on the next cycle.
`timescale 1ns / 1ps
`default_nettype none

module depth_to_rgb_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] depth_word
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  output logic        m_tuser,   // [0] in_range
  output logic        m_tlast
);
  import d2r_pkg::*;

  logic [1:0]         encoding_mode;
  logic [DEPTH_W-1:0] near_limit;
  logic [DEPTH_W-1:0] far_limit;
  logic               cfg_wr;

  logic               en;
  div_beat_t          chain [DIV_STEPS+1];
  div_beat_t          last_beat;
  pixel_t             pix;
  pixel_t             out_pix;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= MODE_GRAY;
      near_limit    <= NEAR_RESET;
      far_limit     <= FAR_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE: encoding_mode <= pwdata[1:0];
        REG_NEAR: near_limit    <= pwdata[DEPTH_W-1:0];
        REG_FAR:  far_limit     <= pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {30'b0, encoding_mode};
      REG_NEAR: prdata = {19'b0, near_limit};
      REG_FAR:  prdata = {19'b0, far_limit};
      default:  prdata = '0;
    endcase
  end

  // front stages
  d2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid && s_tready),
    .in_word    (s_tdata),
    .in_last    (s_tlast),
    .mode       (encoding_mode),
    .near_limit (near_limit),
    .far_limit  (far_limit),
    .out_beat   (chain[0])
  );

  // divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    d2r_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_beat  (chain[i]),
      .out_beat (chain[i+1])
    );
  end

  assign last_beat = chain[DIV_STEPS];

  // pick the output bytes
  always_comb begin
    pix          = '0;
    pix.last     = last_beat.side.last;
    pix.in_range = last_beat.side.ok;
    if (last_beat.side.ok) begin
      case (last_beat.side.sel)
        SEL_GRAY: begin
          pix.blue  = last_beat.quo[BYTE_W-1:0];
          pix.green = last_beat.quo[BYTE_W-1:0];
          pix.red   = last_beat.quo[BYTE_W-1:0];
        end
        SEL_ADAPT: begin
          pix.blue  = last_beat.quo[BYTE_W-1:0];
          pix.green = last_beat.side.green;
          pix.red   = last_beat.side.red;
        end
        default: begin
          pix.blue  = last_beat.side.blue;
          pix.green = last_beat.side.green;
          pix.red   = last_beat.side.red;
        end
      endcase
    end
  end

  // output register with spare slot
  d2r_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (last_beat.valid),
    .in_ready  (en),
    .in_data   (pix),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_pix)
  );

  assign s_tready = en;
  assign m_tdata  = {out_pix.red, out_pix.green, out_pix.blue};
  assign m_tuser  = out_pix.in_range;
  assign m_tlast  = out_pix.last;

`ifndef SYNTHESIS
  // a skipped pixel carries zero bytes
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("skipped pixel with nonzero bytes");

  // grayscale quotient never needs the ninth bit
  a_gray_quo: assert property (@(posedge clk) disable iff (rst)
    last_beat.valid && last_beat.side.ok && last_beat.side.sel == SEL_GRAY
      |-> !last_beat.quo[QUO_W-1])
    else $error("grayscale quotient above 255");

  // input is only held off while a result waits at the output
  a_hold_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(m_tready))
    else $error("input stalled without an output stall");
`endif

endmodule

`default_nettype wire
